/* hw/rtl/battery_level_gauge_unit_defines.svh */
// Assertion macros shared by the battery level gauge checker.
`ifndef BATTERY_LEVEL_GAUGE_UNIT_DEFINES_SVH
`define BATTERY_LEVEL_GAUGE_UNIT_DEFINES_SVH

// Implication checked in the same cycle, switched off while reset is asserted.
`define BLG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("battery level gauge check failed");

// Implication checked in the cycle after the antecedent, switched off while reset is asserted.
`define BLG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("battery level gauge check failed");

// Implication checked in the cycle after the antecedent, also active during reset.
`define BLG_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("battery level gauge reset check failed");

`endif

/* hw/rtl/blg_pkg.sv */
// Shared constants, types and register codes of the battery level gauge.
package blg_pkg;

  // Burst and field widths
  localparam int SAMPLES  = 8;
  localparam int IDX_W    = $clog2(SAMPLES);
  localparam int ADC_W    = 12;
  localparam int HSUM_W   = 11;
  localparam int NSUM_W   = 7;
  localparam int AVG_W    = 13;
  localparam int LEVEL_W  = 3;
  localparam int TIMER_W  = 11;
  localparam int CNT_W    = 8;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

  // Band edges on the offset reading
  localparam logic [ADC_W-1:0] BAND5_EDGE = 12'd394;
  localparam logic [ADC_W-1:0] BAND4_EDGE = 12'd223;
  localparam logic [ADC_W-1:0] BAND3_EDGE = 12'd149;
  localparam logic [ADC_W-1:0] BAND2_EDGE = 12'd93;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  // Level codes
  localparam logic [LEVEL_W-1:0] LVL_UNKNOWN = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_LOW     = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_TWO     = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_THREE   = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_FOUR    = 3'd4;
  localparam logic [LEVEL_W-1:0] LVL_FIVE    = 3'd5;
  localparam logic [LEVEL_W-1:0] LVL_FULL    = 3'd6;

  // Register indexes (word address bits)
  localparam logic [2:0] REG_CLAMP_FLOOR   = 3'd0;
  localparam logic [2:0] REG_CLAMP_CEILING = 3'd1;
  localparam logic [2:0] REG_FULL_THRESH   = 3'd2;
  localparam logic [2:0] REG_FULL_RELEASE  = 3'd3;
  localparam logic [2:0] REG_EXTEND_THRESH = 3'd4;
  localparam logic [2:0] REG_EXTEND_LIMIT  = 3'd5;
  localparam logic [2:0] REG_LOW_REPEAT    = 3'd6;

  // Register reset values
  localparam logic [ADC_W-1:0] RST_CLAMP_FLOOR   = 12'd1117;
  localparam logic [ADC_W-1:0] RST_CLAMP_CEILING = 12'd1555;
  localparam logic [ADC_W-1:0] RST_FULL_THRESH   = 12'd430;
  localparam logic [ADC_W-1:0] RST_FULL_RELEASE  = 12'd405;
  localparam logic [ADC_W-1:0] RST_EXTEND_THRESH = 12'd410;
  localparam logic [ADC_W-1:0] RST_EXTEND_LIMIT  = 12'd1800;
  localparam logic [CNT_W-1:0] RST_LOW_REPEAT    = 8'd10;

  // Configuration bundle handed to the level stage
  typedef struct packed {
    logic [ADC_W-1:0] clamp_floor;
    logic [ADC_W-1:0] clamp_ceiling;
    logic [ADC_W-1:0] full_threshold;
    logic [ADC_W-1:0] full_release;
    logic [ADC_W-1:0] extend_threshold;
    logic [ADC_W-1:0] extend_limit;
    logic [CNT_W-1:0] low_repeat;
  } blg_cfg_t;

endpackage

/* hw/rtl/blg_if.sv */
// Valid/ready channel interfaces for samples in and gauge results out.
interface blg_in_if;
  logic                         valid;
  logic                         ready;
  logic [blg_pkg::ADC_W-1:0]    adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface blg_out_if;
  logic                         valid;
  logic                         ready;
  logic [blg_pkg::LEVEL_W-1:0]  level;
  logic [blg_pkg::ADC_W-1:0]    reading;
  logic                         low_event;

  modport source (output valid, output level, output reading, output low_event, input ready);
  modport sink   (input valid, input level, input reading, input low_event, output ready);
endinterface

/* hw/rtl/blg_regs.sv */
// APB-style configuration register file of the battery level gauge.
module blg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blg_pkg::PADDR_W-1:0]   paddr,
  input  logic [blg_pkg::PDATA_W-1:0]   pwdata,
  output logic [blg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output blg_pkg::blg_cfg_t             cfg
);

  blg_pkg::blg_cfg_t cfg_r;
  logic              wr_en;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[blg_pkg::PADDR_W-1:2];
  assign cfg     = cfg_r;

  // Register writes on the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clamp_floor      <= blg_pkg::RST_CLAMP_FLOOR;
      cfg_r.clamp_ceiling    <= blg_pkg::RST_CLAMP_CEILING;
      cfg_r.full_threshold   <= blg_pkg::RST_FULL_THRESH;
      cfg_r.full_release     <= blg_pkg::RST_FULL_RELEASE;
      cfg_r.extend_threshold <= blg_pkg::RST_EXTEND_THRESH;
      cfg_r.extend_limit     <= blg_pkg::RST_EXTEND_LIMIT;
      cfg_r.low_repeat       <= blg_pkg::RST_LOW_REPEAT;
    end else if (wr_en) begin
      case (reg_idx)
        blg_pkg::REG_CLAMP_FLOOR:   cfg_r.clamp_floor      <= pwdata[blg_pkg::ADC_W-1:0];
        blg_pkg::REG_CLAMP_CEILING: cfg_r.clamp_ceiling    <= pwdata[blg_pkg::ADC_W-1:0];
        blg_pkg::REG_FULL_THRESH:   cfg_r.full_threshold   <= pwdata[blg_pkg::ADC_W-1:0];
        blg_pkg::REG_FULL_RELEASE:  cfg_r.full_release     <= pwdata[blg_pkg::ADC_W-1:0];
        blg_pkg::REG_EXTEND_THRESH: cfg_r.extend_threshold <= pwdata[blg_pkg::ADC_W-1:0];
        blg_pkg::REG_EXTEND_LIMIT:  cfg_r.extend_limit     <= pwdata[blg_pkg::ADC_W-1:0];
        blg_pkg::REG_LOW_REPEAT:    cfg_r.low_repeat       <= pwdata[blg_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      blg_pkg::REG_CLAMP_FLOOR:   prdata = blg_pkg::PDATA_W'(cfg_r.clamp_floor);
      blg_pkg::REG_CLAMP_CEILING: prdata = blg_pkg::PDATA_W'(cfg_r.clamp_ceiling);
      blg_pkg::REG_FULL_THRESH:   prdata = blg_pkg::PDATA_W'(cfg_r.full_threshold);
      blg_pkg::REG_FULL_RELEASE:  prdata = blg_pkg::PDATA_W'(cfg_r.full_release);
      blg_pkg::REG_EXTEND_THRESH: prdata = blg_pkg::PDATA_W'(cfg_r.extend_threshold);
      blg_pkg::REG_EXTEND_LIMIT:  prdata = blg_pkg::PDATA_W'(cfg_r.extend_limit);
      blg_pkg::REG_LOW_REPEAT:    prdata = blg_pkg::PDATA_W'(cfg_r.low_repeat);
      default:                    prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/blg_accum.sv */
// Burst accumulator: sums sample bytes and nibbles and registers the burst average.
module blg_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [blg_pkg::ADC_W-1:0]   in_sample,
  input  logic                        slot_free,
  output logic                        avg_valid,
  output logic [blg_pkg::AVG_W-1:0]   avg
);

  logic [blg_pkg::HSUM_W-1:0] hsum_r, hsum_nxt;
  logic [blg_pkg::NSUM_W-1:0] nsum_r, nsum_nxt;
  logic [blg_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                       avg_valid_r, avg_valid_nxt;
  logic [blg_pkg::AVG_W-1:0]  avg_r, avg_nxt;
  logic [blg_pkg::HSUM_W-1:0] hsum_add;
  logic [blg_pkg::NSUM_W-1:0] nsum_add;
  logic [blg_pkg::AVG_W+2:0]  avg_wide;
  logic                       last;
  logic                       accept;
  logic                       avg_take;

  assign last      = (idx_r == blg_pkg::LAST_IDX);
  assign avg_take  = avg_valid_r && slot_free;
  // A sample that closes a burst needs room in the average register.
  assign in_ready  = !last || !avg_valid_r || slot_free;
  assign accept    = in_valid && in_ready;
  assign avg_valid = avg_valid_r;
  assign avg       = avg_r;

  // Running sums including the sample now on the input.
  assign hsum_add = hsum_r + blg_pkg::HSUM_W'(in_sample[blg_pkg::ADC_W-1:4]);
  assign nsum_add = nsum_r + blg_pkg::NSUM_W'(in_sample[3:0]);
  assign avg_wide = (blg_pkg::AVG_W+3)'({hsum_add, 4'b0000})
                  + (blg_pkg::AVG_W+3)'({nsum_add[blg_pkg::NSUM_W-1:4], 4'b0000});

  always_comb begin
    hsum_nxt      = hsum_r;
    nsum_nxt      = nsum_r;
    idx_nxt       = idx_r;
    avg_nxt       = avg_r;
    avg_valid_nxt = avg_valid_r && !avg_take;
    if (accept) begin
      if (last) begin
        hsum_nxt      = '0;
        nsum_nxt      = '0;
        idx_nxt       = '0;
        avg_nxt       = avg_wide[blg_pkg::AVG_W+2:3];
        avg_valid_nxt = 1'b1;
      end else begin
        hsum_nxt = hsum_add;
        nsum_nxt = nsum_add;
        idx_nxt  = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsum_r      <= '0;
      nsum_r      <= '0;
      idx_r       <= '0;
      avg_valid_r <= 1'b0;
    end else begin
      hsum_r      <= hsum_nxt;
      nsum_r      <= nsum_nxt;
      idx_r       <= idx_nxt;
      avg_valid_r <= avg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_r <= avg_nxt;
  end

endmodule

/* hw/rtl/blg_level.sv */
// Level stage: clamps the average, tracks level, extend timer and low deglitch counter.
module blg_level (
  input  logic                          clk,
  input  logic                          rst_n,
  input  blg_pkg::blg_cfg_t             cfg,
  input  logic                          avg_valid,
  input  logic [blg_pkg::AVG_W-1:0]     avg,
  output logic                          slot_free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [blg_pkg::LEVEL_W-1:0]   out_level,
  output logic [blg_pkg::ADC_W-1:0]     out_reading,
  output logic                          out_low_event
);

  logic [blg_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [blg_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic [blg_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r;
  logic [blg_pkg::LEVEL_W-1:0] out_level_r;
  logic [blg_pkg::ADC_W-1:0]   out_reading_r;
  logic                        out_low_r, low_nxt;
  logic [blg_pkg::AVG_W-1:0]   clamped;
  logic [blg_pkg::ADC_W-1:0]   rd;
  logic [blg_pkg::TIMER_W-1:0] timer_inc;
  logic [blg_pkg::CNT_W-1:0]   cnt_inc;
  logic                        take;

  assign slot_free     = !out_valid_r || out_ready;
  assign take          = avg_valid && slot_free;
  assign out_valid     = out_valid_r;
  assign out_level     = out_level_r;
  assign out_reading   = out_reading_r;
  assign out_low_event = out_low_r;

  // Clamp to the window, ceiling first, then remove the floor offset.
  always_comb begin
    if (avg > blg_pkg::AVG_W'(cfg.clamp_ceiling)) begin
      clamped = blg_pkg::AVG_W'(cfg.clamp_ceiling);
    end else if (avg < blg_pkg::AVG_W'(cfg.clamp_floor)) begin
      clamped = blg_pkg::AVG_W'(cfg.clamp_floor);
    end else begin
      clamped = avg;
    end
    if (clamped >= blg_pkg::AVG_W'(cfg.clamp_floor)) begin
      rd = clamped[blg_pkg::ADC_W-1:0] - cfg.clamp_floor;
    end else begin
      rd = '0;
    end
  end

  assign timer_inc = (timer_r == blg_pkg::TIMER_MAX) ? timer_r : timer_r + 1'b1;
  assign cnt_inc   = (cnt_r == blg_pkg::CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  // Band decision with full hysteresis, extend timer and low deglitch.
  always_comb begin
    level_nxt = level_r;
    timer_nxt = timer_r;
    cnt_nxt   = cnt_r;
    low_nxt   = 1'b0;
    if (rd >= cfg.full_threshold) begin
      level_nxt = blg_pkg::LVL_FULL;
    end else if (rd > blg_pkg::BAND5_EDGE) begin
      if (level_r != blg_pkg::LVL_FULL || rd < cfg.full_release) begin
        level_nxt = blg_pkg::LVL_FIVE;
      end
      if (rd > cfg.extend_threshold) begin
        if (blg_pkg::ADC_W'(timer_inc) > cfg.extend_limit) begin
          timer_nxt = cfg.extend_limit[blg_pkg::TIMER_W-1:0];
          level_nxt = blg_pkg::LVL_FULL;
        end else begin
          timer_nxt = timer_inc;
        end
      end
    end else if (rd > blg_pkg::BAND4_EDGE) begin
      level_nxt = blg_pkg::LVL_FOUR;
      timer_nxt = '0;
    end else if (rd > blg_pkg::BAND3_EDGE) begin
      level_nxt = blg_pkg::LVL_THREE;
      timer_nxt = '0;
    end else if (rd > blg_pkg::BAND2_EDGE) begin
      level_nxt = blg_pkg::LVL_TWO;
      timer_nxt = '0;
    end else begin
      // Low band: immediate from unknown or low, otherwise after repeated bursts.
      if (level_r == blg_pkg::LVL_UNKNOWN || level_r == blg_pkg::LVL_LOW ||
          cnt_inc > cfg.low_repeat) begin
        cnt_nxt   = '0;
        level_nxt = blg_pkg::LVL_LOW;
        timer_nxt = '0;
        low_nxt   = 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  // Tracking state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= blg_pkg::LVL_UNKNOWN;
      timer_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        level_r <= level_nxt;
        timer_r <= timer_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      out_level_r   <= level_nxt;
      out_reading_r <= rd;
      out_low_r     <= low_nxt;
    end
  end

endmodule

/* hw/rtl/battery_level_gauge_unit.sv */
// Top level of the battery level gauge: registers, accumulator and level stage.
//
//   Channel   Direction  Handshake          Payload
//   in_chan   sink       valid/ready        adc_sample[11:0]
//   out_chan  source     valid/ready        level[2:0], reading[11:0], low_event
//   cfg       APB slave  psel/penable       paddr[4:0], pwdata/prdata[31:0]
//
// One sample is taken per cycle while in_ready is high; every eighth sample yields
// one result, through the average register and then the result register.
// rst_n is synchronous: it clears sums, sample count, level, timer and counter.
// While a result waits, samples keep flowing; only a burst-closing sample stalls,
// when both the average register and the result register are occupied.
module battery_level_gauge_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  blg_in_if.sink                        in_chan,
  blg_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blg_pkg::PADDR_W-1:0]   paddr,
  input  logic [blg_pkg::PDATA_W-1:0]   pwdata,
  output logic [blg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  blg_pkg::blg_cfg_t          cfg;
  logic                       slot_free;
  logic                       avg_valid;
  logic [blg_pkg::AVG_W-1:0]  avg;

  blg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  blg_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_sample (in_chan.adc_sample),
    .slot_free (slot_free),
    .avg_valid (avg_valid),
    .avg       (avg)
  );

  blg_level u_level (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .avg_valid     (avg_valid),
    .avg           (avg),
    .slot_free     (slot_free),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_level     (out_chan.level),
    .out_reading   (out_chan.reading),
    .out_low_event (out_chan.low_event)
  );

endmodule

/* hw/rtl/blg_checker.sv */
// Port-level checker for the battery level gauge, bound to the top level.
`include "battery_level_gauge_unit_defines.svh"

module blg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [blg_pkg::LEVEL_W-1:0]   out_level,
  input logic [blg_pkg::ADC_W-1:0]     out_reading,
  input logic                          out_low_event
);

  // A stalled result keeps its payload.
  `BLG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_level) && $stable(out_reading) && $stable(out_low_event))

  // Every result carries a known level from low to full.
  `BLG_ASSERT_NOW(a_level_known, out_valid, out_level != blg_pkg::LVL_UNKNOWN && out_level != 3'd7)

  // A low event always comes with the low level.
  `BLG_ASSERT_NOW(a_low_event_level, out_valid && out_low_event, out_level == blg_pkg::LVL_LOW)

  // Reset empties the result register.
  `BLG_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind battery_level_gauge_unit blg_checker u_blg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_level     (out_chan.level),
  .out_reading   (out_chan.reading),
  .out_low_event (out_chan.low_event)
);

/* dv/battery_level_gauge_unit_test.sv */
// Self-checking testbench for the battery level gauge: bursts in, level reports out.
`timescale 1ns / 100ps

module battery_level_gauge_unit_test;

  // Index with no register behind it, used to check that such writes are ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [blg_pkg::LEVEL_W-1:0] level;
    logic [blg_pkg::ADC_W-1:0]   reading;
    logic                        low_event;
  } gauge_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [blg_pkg::PADDR_W-1:0] paddr;
  logic [blg_pkg::PDATA_W-1:0] pwdata;
  logic [blg_pkg::PDATA_W-1:0] prdata;
  logic pready;

  blg_in_if  in_if ();
  blg_out_if out_if ();

  battery_level_gauge_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Samples waiting to be sent, and level reports the gauge still owes us.
  logic [blg_pkg::ADC_W-1:0] sample_queue[$];
  gauge_result_t             level_reports_due[$];
  int                        mismatch_count = 0;

  // Our own copy of the gauge: register settings and burst/level state.
  blg_pkg::blg_cfg_t            cfg_model;
  logic [blg_pkg::HSUM_W-1:0]   acc_high;
  logic [blg_pkg::NSUM_W-1:0]   acc_nibble;
  logic [blg_pkg::IDX_W-1:0]    acc_count;
  logic [blg_pkg::LEVEL_W-1:0]  lvl;
  logic [blg_pkg::TIMER_W-1:0]  ext_timer;
  logic [blg_pkg::CNT_W-1:0]    low_cnt;

  // Idle-free stretches for each side.
  int in_calm = 0;
  int out_calm = 0;
  int send_wait;
  int hold_off;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] gauge mismatch: %s", $time, what);
  endtask

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Accumulate one accepted sample; on the last of a burst, work out the report.
  task automatic gauge_accumulate(input logic [blg_pkg::ADC_W-1:0] s);
    int avg;
    int r;
    int nxt;
    logic commit;
    logic low;
    gauge_result_t res;
    acc_high   = acc_high + blg_pkg::HSUM_W'(s[11:4]);
    acc_nibble = acc_nibble + blg_pkg::NSUM_W'(s[3:0]);
    if (acc_count != blg_pkg::LAST_IDX) begin
      acc_count++;
    end else begin
      avg = ((int'(acc_high) << 4) + (int'(acc_nibble) & 'hF0)) >> 3;
      acc_high   = '0;
      acc_nibble = '0;
      acc_count  = '0;

      // Clamp to the window, ceiling tested first; a ceiling below the floor gives a zero reading.
      if (avg > int'(cfg_model.clamp_ceiling)) begin
        avg = int'(cfg_model.clamp_ceiling);
      end else if (avg < int'(cfg_model.clamp_floor)) begin
        avg = int'(cfg_model.clamp_floor);
      end
      r = (avg >= int'(cfg_model.clamp_floor)) ? avg - int'(cfg_model.clamp_floor) : 0;

      low = 1'b0;
      if (r >= int'(cfg_model.full_threshold)) begin
        lvl = blg_pkg::LVL_FULL;
      end else if (r > int'(blg_pkg::BAND5_EDGE)) begin
        // Full only drops to five once the reading falls below the release point.
        if (lvl == blg_pkg::LVL_FULL) begin
          if (r < int'(cfg_model.full_release)) lvl = blg_pkg::LVL_FIVE;
        end else begin
          lvl = blg_pkg::LVL_FIVE;
        end
        // Charge-extend timer saturates and forces full once past its limit.
        if (r > int'(cfg_model.extend_threshold)) begin
          nxt = (ext_timer < blg_pkg::TIMER_MAX) ? int'(ext_timer) + 1
                                                 : int'(blg_pkg::TIMER_MAX);
          if (nxt > int'(cfg_model.extend_limit)) begin
            ext_timer = cfg_model.extend_limit[blg_pkg::TIMER_W-1:0];
            lvl = blg_pkg::LVL_FULL;
          end else begin
            ext_timer = blg_pkg::TIMER_W'(nxt);
          end
        end
      end else if (r > int'(blg_pkg::BAND4_EDGE)) begin
        lvl = blg_pkg::LVL_FOUR;
        ext_timer = '0;
      end else if (r > int'(blg_pkg::BAND3_EDGE)) begin
        lvl = blg_pkg::LVL_THREE;
        ext_timer = '0;
      end else if (r > int'(blg_pkg::BAND2_EDGE)) begin
        lvl = blg_pkg::LVL_TWO;
        ext_timer = '0;
      end else begin
        // Low band: commit at once from unknown or low, else after the deglitch count.
        commit = (lvl == blg_pkg::LVL_UNKNOWN || lvl == blg_pkg::LVL_LOW);
        if (!commit) begin
          if (low_cnt != blg_pkg::CNT_MAX) low_cnt++;
          commit = (low_cnt > cfg_model.low_repeat);
        end
        if (commit) begin
          low_cnt = '0;
          lvl = blg_pkg::LVL_LOW;
          ext_timer = '0;
          low = 1'b1;
        end
      end

      res.level     = lvl;
      res.reading   = r[blg_pkg::ADC_W-1:0];
      res.low_event = low;
      level_reports_due.push_back(res);
    end
  endtask

  task automatic check_gauge_result(input logic [blg_pkg::LEVEL_W-1:0] level,
                                    input logic [blg_pkg::ADC_W-1:0] reading,
                                    input logic low_ev);
    gauge_result_t want;
    if (level_reports_due.size() == 0) begin
      report_mismatch($sformatf("report with none due: level %0d reading %0d low %0d",
                                level, reading, low_ev));
    end else begin
      want = level_reports_due.pop_front();
      if (level !== want.level)
        report_mismatch($sformatf("level %0d, expected %0d", level, want.level));
      if (reading !== want.reading)
        report_mismatch($sformatf("reading %0d, expected %0d", reading, want.reading));
      if (low_ev !== want.low_event)
        report_mismatch($sformatf("low_event %0d, expected %0d", low_ev, want.low_event));
    end
  endtask

  // Sample driver: presents queued samples and predicts each one on its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.adc_sample <= '0;
      send_wait = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) gauge_accumulate(in_if.adc_sample);
      if (send_wait > 0) begin
        in_if.valid <= 1'b0;
        send_wait--;
      end else if (sample_queue.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.adc_sample <= sample_queue.pop_front();
        send_wait = pick_gap(in_calm);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Report monitor: checks every transfer and stalls the result side at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_off = 0;
    end else begin
      if (out_if.valid && out_if.ready)
        check_gauge_result(out_if.level, out_if.reading, out_if.low_event);
      if (hold_off > 0) begin
        out_if.ready <= 1'b0;
        hold_off--;
      end else begin
        out_if.ready <= 1'b1;
        hold_off = pick_gap(out_calm);
      end
    end
  end

  // One register write over the configuration port; upper data bits are random.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] word;
    word = $urandom;
    if (idx == blg_pkg::REG_LOW_REPEAT) begin
      word[blg_pkg::CNT_W-1:0] = value[blg_pkg::CNT_W-1:0];
    end else begin
      word[blg_pkg::ADC_W-1:0] = value[blg_pkg::ADC_W-1:0];
    end
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      blg_pkg::REG_CLAMP_FLOOR:   cfg_model.clamp_floor      = word[blg_pkg::ADC_W-1:0];
      blg_pkg::REG_CLAMP_CEILING: cfg_model.clamp_ceiling    = word[blg_pkg::ADC_W-1:0];
      blg_pkg::REG_FULL_THRESH:   cfg_model.full_threshold   = word[blg_pkg::ADC_W-1:0];
      blg_pkg::REG_FULL_RELEASE:  cfg_model.full_release     = word[blg_pkg::ADC_W-1:0];
      blg_pkg::REG_EXTEND_THRESH: cfg_model.extend_threshold = word[blg_pkg::ADC_W-1:0];
      blg_pkg::REG_EXTEND_LIMIT:  cfg_model.extend_limit     = word[blg_pkg::ADC_W-1:0];
      blg_pkg::REG_LOW_REPEAT:    cfg_model.low_repeat       = word[blg_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_gauge(input int floor_v, input int ceil_v, input int full_v,
                               input int release_v, input int ext_v, input int limit_v,
                               input int repeat_v);
    cfg_write(blg_pkg::REG_CLAMP_FLOOR, floor_v);
    cfg_write(blg_pkg::REG_CLAMP_CEILING, ceil_v);
    cfg_write(blg_pkg::REG_FULL_THRESH, full_v);
    cfg_write(blg_pkg::REG_FULL_RELEASE, release_v);
    cfg_write(blg_pkg::REG_EXTEND_THRESH, ext_v);
    cfg_write(blg_pkg::REG_EXTEND_LIMIT, limit_v);
    cfg_write(blg_pkg::REG_LOW_REPEAT, repeat_v);
    cfg_write(REG_UNUSED, $urandom);
  endtask

  // A plausible window and thresholds around the level bands.
  task automatic program_random_gauge();
    int floor_v;
    int ceil_v;
    int full_v;
    floor_v = $urandom_range(0, 3000);
    ceil_v  = floor_v + $urandom_range(100, 1000);
    if (ceil_v > 4095) ceil_v = 4095;
    full_v  = $urandom_range(395, 700);
    program_gauge(floor_v, ceil_v, full_v, $urandom_range(380, full_v),
                  $urandom_range(380, 600),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 40),
                  $urandom_range(0, 12));
  endtask

  // Eight samples scattered tightly around a target average.
  task automatic queue_burst(input int centre, input int spread);
    int s;
    repeat (blg_pkg::SAMPLES) begin
      s = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      sample_queue.push_back(blg_pkg::ADC_W'(s));
    end
  endtask

  // Runs of bursts aimed at one band or threshold, with some pure noise mixed in.
  task automatic queue_random_bursts(input int bursts);
    int left;
    int region;
    int run;
    int r;
    int span;
    left = bursts;
    span = int'(cfg_model.clamp_ceiling) - int'(cfg_model.clamp_floor);
    while (left > 0) begin
      region = $urandom_range(0, 8);
      if (region == 0 && cfg_model.low_repeat < 32 && $urandom_range(0, 1))
        run = int'(cfg_model.low_repeat) + $urandom_range(1, 3);
      else
        run = $urandom_range(1, 10);
      left -= run;
      repeat (run) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat (blg_pkg::SAMPLES) begin
            case ($urandom_range(0, 3))
              0:       sample_queue.push_back('0);
              1:       sample_queue.push_back('1);
              default: sample_queue.push_back(blg_pkg::ADC_W'($urandom));
            endcase
          end
        end else begin
          case (region)
            0: r = $urandom_range(0, 93);
            1: r = $urandom_range(94, 149);
            2: r = $urandom_range(150, 223);
            3: r = $urandom_range(224, 394);
            4: r = $urandom_range(395, (span > 395) ? span : 395);
            5: r = int'(cfg_model.full_threshold) + int'($urandom_range(0, 6)) - 3;
            6: r = int'(cfg_model.full_release) + int'($urandom_range(0, 6)) - 3;
            7: r = int'(cfg_model.extend_threshold) + int'($urandom_range(0, 6)) - 3;
            default: r = int'($urandom_range(0, 4095)) - int'(cfg_model.clamp_floor);
          endcase
          queue_burst(int'(cfg_model.clamp_floor) + r, $urandom_range(0, 3));
        end
      end
    end
  endtask

  // Wait until every queued sample is sent and every report has come back.
  task automatic drain();
    while (sample_queue.size() != 0 || in_if.valid || level_reports_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_if.valid      = 1'b0;
    in_if.adc_sample = '0;
    out_if.ready     = 1'b0;

    cfg_model.clamp_floor      = blg_pkg::RST_CLAMP_FLOOR;
    cfg_model.clamp_ceiling    = blg_pkg::RST_CLAMP_CEILING;
    cfg_model.full_threshold   = blg_pkg::RST_FULL_THRESH;
    cfg_model.full_release     = blg_pkg::RST_FULL_RELEASE;
    cfg_model.extend_threshold = blg_pkg::RST_EXTEND_THRESH;
    cfg_model.extend_limit     = blg_pkg::RST_EXTEND_LIMIT;
    cfg_model.low_repeat       = blg_pkg::RST_LOW_REPEAT;
    acc_high   = '0;
    acc_nibble = '0;
    acc_count  = '0;
    lvl        = blg_pkg::LVL_UNKNOWN;
    ext_timer  = '0;
    low_cnt    = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bursts on reset settings: low from unknown commits at once,
    // full scale, then mixed bit patterns that clamp at the ceiling.
    @(negedge clk);
    queue_burst(0, 0);
    queue_burst(4095, 0);
    sample_queue.push_back(12'hAAA);
    sample_queue.push_back(12'h555);
    sample_queue.push_back(12'hAAA);
    sample_queue.push_back(12'h555);
    sample_queue.push_back(12'h0F0);
    sample_queue.push_back(12'h00F);
    sample_queue.push_back(12'hF00);
    sample_queue.push_back(12'h3C3);
    drain();

    // Random traffic on the reset settings.
    queue_random_bursts(25);
    drain();

    // A few random settings.
    repeat (3) begin
      program_random_gauge();
      @(negedge clk);
      queue_random_bursts(15);
      drain();
    end

    // Every register at zero: the reading is always zero and always full.
    program_gauge(0, 0, 0, 0, 0, 0, 0);
    @(negedge clk);
    queue_random_bursts(6);
    drain();

    // Wide window, full unreachable, timer forcing full on its first count.
    program_gauge(0, 4095, 4095, 4095, 0, 0, 255);
    @(negedge clk);
    queue_random_bursts(20);
    drain();

    // Every register at its maximum.
    program_gauge(4095, 4095, 4095, 4095, 4095, 4095, 255);
    @(negedge clk);
    queue_random_bursts(8);
    drain();

    // Ceiling below floor: the reading saturates at zero.
    program_gauge($urandom_range(2000, 4095), $urandom_range(0, 1999), $urandom_range(0, 700),
                  $urandom_range(0, 700), $urandom_range(0, 700), $urandom_range(0, 40),
                  $urandom_range(0, 12));
    @(negedge clk);
    queue_random_bursts(10);
    drain();

    // Extend timer: it counts on every high burst and forces full once past its
    // limit; lowering the limit afterwards pulls the held count down to it.
    program_gauge(0, 4095, 4095, 0, 0, 12, 10);
    @(negedge clk);
    queue_burst(300, 2);
    repeat (16) queue_burst(2000, 3);
    drain();
    cfg_write(blg_pkg::REG_EXTEND_LIMIT, 5);
    @(negedge clk);
    repeat (3) queue_burst(2000, 3);
    drain();

    // Low deglitch: from level four the low level waits for the repeat count;
    // with a count of zero the first low burst commits.
    program_gauge(0, 4095, 4095, 0, 4095, 4095, 8);
    @(negedge clk);
    queue_burst(300, 2);
    repeat (12) queue_burst(20, 3);
    drain();
    cfg_write(blg_pkg::REG_LOW_REPEAT, 0);
    @(negedge clk);
    queue_burst(300, 2);
    repeat (2) queue_burst(20, 3);
    drain();

    // More random settings to finish.
    repeat (2) begin
      program_random_gauge();
      @(negedge clk);
      queue_random_bursts(10);
      drain();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
